/* rtl/ihs_pkg.sv */
// ----------------------------------------------------------------------------
// Image header sniffer package
// Shared sizes, image-kind codes and the magic byte patterns.
// ----------------------------------------------------------------------------
package ihs_pkg;

    localparam int HEADER_BYTES = 16;
    localparam int SIG_BYTES    = 12;
    localparam int POS_W        = $clog2(HEADER_BYTES + 1);
    localparam int IDX_W        = $clog2(SIG_BYTES);

    typedef enum logic [2:0] {
        KIND_NONE = 3'd0,
        KIND_JPEG = 3'd1,
        KIND_PNG  = 3'd2,
        KIND_SVG  = 3'd3,
        KIND_WEBP = 3'd4,
        KIND_GIF  = 3'd5,
        KIND_BMP  = 3'd6,
        KIND_HEIF = 3'd7
    } t_kind;

    typedef logic [POS_W-1:0] t_pos;

    localparam logic [23:0] SIG_JPEG   = 24'hFFD8FF;
    localparam logic [63:0] SIG_PNG    = 64'h89504E470D0A1A0A;
    localparam logic [31:0] SIG_SVG_LO = 32'h3C737667;
    localparam logic [31:0] SIG_SVG_UP = 32'h3C535647;
    localparam logic [31:0] SIG_RIFF   = 32'h52494646;
    localparam logic [31:0] SIG_WEBP   = 32'h57454250;
    localparam logic [47:0] SIG_GIF87  = 48'h474946383761;
    localparam logic [47:0] SIG_GIF89  = 48'h474946383961;
    localparam logic [15:0] SIG_BMP    = 16'h424D;
    localparam logic [31:0] SIG_FTYP   = 32'h66747970;
    localparam logic [31:0] SIG_HEIC   = 32'h68656963;
    localparam logic [31:0] SIG_MIF1   = 32'h6D696631;

endpackage

/* rtl/image_header_sniffer.sv */
// ----------------------------------------------------------------------------
// Image header sniffer
// Classifies a file as one of several image kinds from its leading bytes.
// ----------------------------------------------------------------------------
// The block takes one file byte per item and accepts a new item in every
// cycle while o_in_stall is low. The result item for a file comes out in
// the cycle after its sixteenth byte is taken, or after its last byte when
// the file is shorter, with KIND_NONE in that case. Later bytes give no
// item; the byte after an end_of_file byte starts a new file. A result in
// the output register does not block input unless the output side stalls.
module image_header_sniffer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [7:0]           i_file_byte,
    input  logic                 i_end_of_file,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [2:0]           o_image_kind
);
    import ihs_pkg::*;

    localparam t_pos POS_LAST = t_pos'(HEADER_BYTES - 1);
    localparam t_pos POS_FULL = t_pos'(HEADER_BYTES);
    localparam t_pos POS_SIG  = t_pos'(SIG_BYTES);
    localparam t_pos POS_ONE  = t_pos'(1);
    localparam int   VW       = SIG_BYTES * 8;

    logic [7:0]          r_store [SIG_BYTES];
    t_pos                r_pos;
    t_pos                n_pos;
    logic                r_valid;
    logic                n_valid;
    t_kind               r_kind;
    t_kind               n_kind;
    logic                in_take;
    logic                collecting;
    logic                result_now;
    logic [VW-1:0]       hdr;
    t_kind               kind;

    assign o_in_stall   = r_valid && i_out_stall;
    assign in_take      = i_in_valid && !o_in_stall;
    assign collecting   = r_pos < POS_FULL;
    assign result_now   = in_take && collecting && ((r_pos == POS_LAST) || i_end_of_file);
    assign o_out_valid  = r_valid;
    assign o_image_kind = r_kind;

    // The byte being taken stands in for its own store entry.
    always_comb begin
        for (int i = 0; i < SIG_BYTES; i++) begin
            if (r_pos == t_pos'(i)) begin
                hdr[(SIG_BYTES - 1 - i) * 8 +: 8] = i_file_byte;
            end else begin
                hdr[(SIG_BYTES - 1 - i) * 8 +: 8] = r_store[i];
            end
        end
    end

    always_comb begin
        if (hdr[VW-1 -: 24] == SIG_JPEG) begin
            kind = KIND_JPEG;
        end else if (hdr[VW-1 -: 64] == SIG_PNG) begin
            kind = KIND_PNG;
        end else if (hdr[VW-1 -: 32] == SIG_SVG_LO || hdr[VW-1 -: 32] == SIG_SVG_UP) begin
            kind = KIND_SVG;
        end else if (hdr[VW-1 -: 32] == SIG_RIFF && hdr[VW-65 -: 32] == SIG_WEBP) begin
            kind = KIND_WEBP;
        end else if (hdr[VW-1 -: 48] == SIG_GIF87 || hdr[VW-1 -: 48] == SIG_GIF89) begin
            kind = KIND_GIF;
        end else if (hdr[VW-1 -: 16] == SIG_BMP) begin
            kind = KIND_BMP;
        end else if (hdr[VW-33 -: 32] == SIG_FTYP &&
                     (hdr[VW-65 -: 32] == SIG_HEIC || hdr[VW-65 -: 32] == SIG_MIF1)) begin
            kind = KIND_HEIF;
        end else begin
            kind = KIND_NONE;
        end
    end

    always_comb begin
        n_pos   = r_pos;
        n_valid = r_valid && i_out_stall;
        n_kind  = r_kind;
        if (in_take) begin
            if (i_end_of_file) begin
                n_pos = '0;
            end else if (collecting) begin
                n_pos = r_pos + POS_ONE;
            end
        end
        if (result_now) begin
            n_valid = 1'b1;
            n_kind  = (r_pos == POS_LAST) ? kind : KIND_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        if (in_take && r_pos < POS_SIG) begin
            r_store[r_pos[IDX_W-1:0]] <= i_file_byte;
        end
    end

endmodule
